// ----- design/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // Broadcast to every cell; push and pop are only set when the beat really acts.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } cell_cmd_t;

endpackage

// ----- design/spq_if.sv -----
// Request and response channel interfaces for the sorted priority queue.
interface spq_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic signed [31:0] key;
  logic [15:0]       tag;

  modport source (output valid, output req_type, output key, output tag, input ready);
  modport sink   (input valid, input req_type, input key, input tag, output ready);
endinterface

interface spq_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] out_key;
  logic [15:0]       out_tag;
  logic [4:0]        occupancy;

  modport source (output valid, output status, output out_key, output out_tag,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input occupancy, output ready);
endinterface

// ----- design/spq_cell.sv -----
// One slot of the sorted list: holds an entry, shifts right on push, left on pop.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  entry_t    left_i,
  input  logic      left_ge_i,
  input  entry_t    right_i,
  output entry_t    entry_o,
  output logic      ge_o
);

  logic                    valid_q, valid_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [TAG_W-1:0]        tag_q, tag_d;

  // New key belongs at or ahead of this slot.
  assign ge_o = !valid_q || ($signed(cmd_i.key) >= $signed(key_q));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (cmd_i.push) begin
      if (left_ge_i) begin
        valid_d = left_i.valid;
        key_d   = left_i.key;
        tag_d   = left_i.tag;
      end else if (ge_o) begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
        tag_d   = cmd_i.tag;
      end
    end else if (cmd_i.pop) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      tag_d   = right_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: cell row, entry count and response register.

// Max-priority queue of DEPTH entries kept sorted in a row of cells, largest
// signed Q16.16 key at the front; equal keys leave newest first. Every cell
// compares the incoming key with its own entry in the same cycle, so a push or
// pop is taken each unstalled cycle; its response appears next cycle, held in
// an output register while the sink stalls; a new request is accepted in the
// same cycle the held response is taken. Push to a full queue returns status
// full, pop of an empty queue returns status empty; both leave the queue
// unchanged. Occupancy is the entry count after the request, low 5 bits.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  entry_t            cell_entry [DEPTH];
  logic [DEPTH-1:0]  cell_ge;
  logic [DEPTH-1:0]  valid_vec;
  cell_cmd_t         cmd;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              full, empty, req_fire, is_push, is_pop;

  logic              rsp_valid_q;
  status_e           status_q, status_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;
  logic [TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [CNT_W+OCC_W-1:0] count_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_push     = (req_i.req_type == REQ_PUSH);
  assign is_pop      = (req_i.req_type == REQ_POP);
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);

  assign cmd.push = req_fire && is_push && !full;
  assign cmd.pop  = req_fire && is_pop && !empty;
  assign cmd.key  = req_i.key;
  assign cmd.tag  = req_i.tag;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_ge;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_entry),
      .left_ge_i (left_ge),
      .right_i   (right_entry),
      .entry_o   (cell_entry[i]),
      .ge_o      (cell_ge[i])
    );

    assign valid_vec[i] = cell_entry[i].valid;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_ext = (CNT_W + OCC_W)'(count_d);

  always_comb begin
    status_d  = STATUS_OK;
    out_key_d = '0;
    out_tag_d = '0;
    occ_d     = count_ext[OCC_W-1:0];
    if (is_push) begin
      if (full) begin
        status_d = STATUS_FULL;
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        out_key_d = cell_entry[0].key;
        out_tag_d = cell_entry[0].tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_tag_q <= out_tag_d;
      occ_q     <= occ_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.out_key   = out_key_q;
  assign rsp_o.out_tag   = out_tag_q;
  assign rsp_o.occupancy = occ_q;

  // Entry count tracks the occupied cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == count_q)
    else $error("entry count differs from occupied cells");

  // Occupied cells always form a solid run from the front.
  a_packed_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("hole in the cell row");

  // A push beat on a full queue comes back rejected.
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && is_push && full) |=> (rsp_o.valid && rsp_o.status == STATUS_FULL))
    else $error("push on full queue not rejected");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sorted priority queue: directed table, then random push/pop phases.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic [OCC_W-1:0]        occ;
  } resp_t;

  typedef struct {
    req_type_e               req;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    bit                      typed;  // expected response given in the table
    resp_t                   want;
  } beat_t;

  localparam int RAND_BEATS = 1900;

  logic clk;
  logic rst_n;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the sorted list, largest key at index 0
  logic signed [KEY_W-1:0] list_key [DEPTH];
  logic [TAG_W-1:0]        list_tag [DEPTH];
  int                      list_cnt = 0;

  beat_t beat_q [$];
  resp_t resp_expect_q [$];
  int    mismatch_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return (int'($urandom_range(0, 6)) - 3) * 65536;  // few values, many ties
      default: return $urandom;
    endcase
  endfunction

  // Applies one beat to the shadow list and returns the response it should give
  function automatic resp_t step_sorted_list(input req_type_e req,
                                             input logic signed [KEY_W-1:0] key,
                                             input logic [TAG_W-1:0] tag);
    resp_t r;
    int    pos;
    r = '0;
    if (req == REQ_PUSH) begin
      if (list_cnt >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < list_cnt && !(key >= list_key[pos])) pos++;
        for (int i = list_cnt; i > pos; i--) begin
          list_key[i] = list_key[i-1];
          list_tag[i] = list_tag[i-1];
        end
        list_key[pos] = key;
        list_tag[pos] = tag;
        list_cnt++;
        r.status = STATUS_OK;
      end
    end else begin
      if (list_cnt == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.status = STATUS_OK;
        r.key    = list_key[0];
        r.tag    = list_tag[0];
        for (int i = 1; i < list_cnt; i++) begin
          list_key[i-1] = list_key[i];
          list_tag[i-1] = list_tag[i];
        end
        list_cnt--;
      end
    end
    r.occ = OCC_W'(list_cnt);
    return r;
  endfunction

  task automatic add_row(input req_type_e req, input logic [KEY_W-1:0] key,
                         input logic [TAG_W-1:0] tag, input bit typed,
                         input logic [1:0] st, input logic [KEY_W-1:0] ek,
                         input logic [TAG_W-1:0] et, input logic [OCC_W-1:0] occ);
    beat_t b;
    b.req        = req;
    b.key        = key;
    b.tag        = tag;
    b.typed      = typed;
    b.want.status = st;
    b.want.key   = ek;
    b.want.tag   = et;
    b.want.occ   = occ;
    beat_q.insert(beat_q.size(), b);
  endtask

  // Request side
  initial begin : drive_req
    beat_t       cur;
    resp_t       pred;
    int unsigned gap;
    int unsigned run_len;
    int unsigned push_pct;
    int          made;
    bit          steady;

    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH;
    req_if.key      = '0;
    req_if.tag      = '0;

    //      req       key            tag       typed status        key            tag      occ
    add_row(REQ_POP,  32'h00000000, 16'h0000, 1'b1, STATUS_EMPTY, 32'h00000000, 16'h0000, 5'd0);
    add_row(REQ_PUSH, 32'h7fffffff, 16'hffff, 1'b1, STATUS_OK,    32'h00000000, 16'h0000, 5'd1);
    add_row(REQ_PUSH, 32'hffff8000, 16'h0001, 1'b1, STATUS_OK,    32'h00000000, 16'h0000, 5'd2);
    add_row(REQ_PUSH, 32'h00000000, 16'haaaa, 1'b1, STATUS_OK,    32'h00000000, 16'h0000, 5'd3);
    add_row(REQ_PUSH, 32'h00000000, 16'h5555, 1'b1, STATUS_OK,    32'h00000000, 16'h0000, 5'd4);
    add_row(REQ_POP,  32'hffffffff, 16'hffff, 1'b1, STATUS_OK,    32'h7fffffff, 16'hffff, 5'd3);
    // tie on key zero: newest comes out first
    add_row(REQ_POP,  32'h00000000, 16'h0000, 1'b1, STATUS_OK,    32'h00000000, 16'h5555, 5'd2);
    // fill to the brim
    add_row(REQ_PUSH, 32'h80000000, 16'h0000, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h7fffffff, 16'h1111, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h00010000, 16'h2222, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'hffff0000, 16'h3333, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h00000000, 16'h4444, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h00000001, 16'h5555, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'hffffffff, 16'h6666, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h40000000, 16'h7777, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'hc0000000, 16'h8888, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h00008000, 16'h9999, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h12345678, 16'hbbbb, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'hedcba987, 16'hcccc, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h7fffffff, 16'hdddd, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h80000000, 16'heeee, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h00000000, 16'h0f0f, 1'b1, STATUS_FULL,  32'h00000000, 16'h0000, 5'd16);
    add_row(REQ_POP,  32'h5a5a5a5a, 16'ha5a5, 1'b0, STATUS_OK,    32'h0, 16'h0, 5'd0);
    add_row(REQ_PUSH, 32'h80000000, 16'hf0f0, 1'b1, STATUS_OK,    32'h00000000, 16'h0000, 5'd16);
    add_row(REQ_PUSH, 32'h7fffffff, 16'hffff, 1'b1, STATUS_FULL,  32'h00000000, 16'h0000, 5'd16);

    // Random phases: fill-heavy, drain-heavy or balanced runs
    made = 0;
    while (made < RAND_BEATS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(10, 80);
      for (int i = 0; i < run_len && made < RAND_BEATS; i++) begin
        add_row(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, rand_key(),
                16'($urandom_range(0, 65535)), 1'b0, STATUS_OK, 32'h0, 16'h0, 5'd0);
        made++;
      end
    end

    steady = 1'b0;
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    while (beat_q.size() > 0) begin
      cur = beat_q[0];
      beat_q.delete(0);
      req_if.valid    <= 1'b1;
      req_if.req_type <= cur.req;
      req_if.key      <= cur.key;
      req_if.tag      <= cur.tag;
      do @(posedge clk); while (!req_if.ready);
      pred = step_sorted_list(cur.req, cur.key, cur.tag);
      resp_expect_q.insert(resp_expect_q.size(), cur.typed ? cur.want : pred);
      if ($urandom_range(0, 99) == 0) steady = !steady;
      gap = steady ? 0 : idle_len();
      // keep valid high across back-to-back beats
      if (gap > 0 || beat_q.size() == 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    while (resp_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && resp_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Response side
  initial begin : take_rsp
    resp_t       got;
    resp_t       want;
    int unsigned stall_left;
    bit          steady;

    rsp_if.ready = 1'b0;
    stall_left   = 0;
    steady       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.key    = rsp_if.out_key;
        got.tag    = rsp_if.out_tag;
        got.occ    = rsp_if.occupancy;
        if (resp_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: status %0d key %h tag %h occ %0d",
                     got.status, got.key, got.tag, got.occ);
        end else begin
          want = resp_expect_q[0];
          resp_expect_q.delete(0);
          if (got.status !== want.status || got.key !== want.key ||
              got.tag !== want.tag || got.occ !== want.occ) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: status %0d/%0d key %h/%h tag %h/%h occ %0d/%0d (exp/got)",
                       want.status, got.status, want.key, got.key,
                       want.tag, got.tag, want.occ, got.occ);
          end
        end
      end
      if (!rst_n) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
      if ($urandom_range(0, 299) == 0) steady = !steady;
    end
  end

endmodule
